@@ hw/rtl/hid_keyboard_report_builder_unit_defines.svh @@
// ----------------------------------------------------------------------------
// HID keyboard report builder: assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HID_KEYBOARD_REPORT_BUILDER_UNIT_DEFINES_SVH
`define HID_KEYBOARD_REPORT_BUILDER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HKRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HKRB_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define HKRB_ASSERT(lbl, prop, msg)
`define HKRB_NEVER(lbl, expr, msg)
`endif

`endif

@@ hw/rtl/hkrb_pkg.sv @@
// ----------------------------------------------------------------------------
// HID keyboard report builder: shared types and constants
// Event and report byte layouts, op codes, decoded command format.
// ----------------------------------------------------------------------------
package hkrb_pkg;

  localparam int KEY_SLOT_COUNT = 6;
  localparam int HEADER_LEN     = 3;
  localparam int REPORT_LEN     = HEADER_LEN + KEY_SLOT_COUNT;
  localparam int CNT_W          = $clog2(REPORT_LEN);
  localparam int SLOT_W         = (KEY_SLOT_COUNT > 1) ? $clog2(KEY_SLOT_COUNT) : 1;
  localparam int IDX_W          = 4;
  localparam int QDEPTH         = 2;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QCNT_W         = $clog2(QDEPTH + 1);

  localparam logic [7:0] REPORT_ID_RST = 8'h01;

  localparam logic [1:0] OP_MOD     = 2'd0;
  localparam logic [1:0] OP_KEY     = 2'd1;
  localparam logic [1:0] OP_REL_ALL = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic       pressed;
    logic [7:0] code;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       report_byte;
    logic [IDX_W-1:0] byte_index;
    logic             last;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_NOP       = 3'd0,
    CMD_MOD_SET   = 3'd1,
    CMD_MOD_CLR   = 3'd2,
    CMD_KEY_PRESS = 3'd3,
    CMD_KEY_REL   = 3'd4,
    CMD_CLR_ALL   = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] code;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ hw/rtl/hkrb_front.sv @@
// ----------------------------------------------------------------------------
// HID keyboard report builder: front end
// Accepts events and decodes them into commands for the queue.
// ----------------------------------------------------------------------------
module hkrb_front import hkrb_pkg::*; (
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  input  q_status_t q_status,
  output logic      q_push,
  output cmd_t      q_cmd
);

  assign busy   = q_status.full;
  assign q_push = start && !q_status.full;

  always_comb begin
    q_cmd.code = in_item.code;
    unique case (in_item.op)
      OP_MOD:     q_cmd.kind = in_item.pressed ? CMD_MOD_SET : CMD_MOD_CLR;
      OP_KEY:     q_cmd.kind = in_item.pressed ? CMD_KEY_PRESS : CMD_KEY_REL;
      OP_REL_ALL: q_cmd.kind = CMD_CLR_ALL;
      default:    q_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

@@ hw/rtl/hkrb_queue.sv @@
// ----------------------------------------------------------------------------
// HID keyboard report builder: command queue
// Small FIFO between the front end and the report engine.
// ----------------------------------------------------------------------------
`include "hid_keyboard_report_builder_unit_defines.svh"

module hkrb_queue import hkrb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head_cmd,
  output q_status_t status
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign status.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign status.empty = (cnt_r == '0);
  assign head_cmd     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  `HKRB_NEVER(a_q_overflow, push && status.full, "queue push while full")
  `HKRB_NEVER(a_q_underflow, pop && status.empty, "queue pop while empty")
  `HKRB_NEVER(a_q_count, cnt_r > QCNT_W'(QDEPTH), "queue count out of range")

endmodule

@@ hw/rtl/hkrb_back.sv @@
// ----------------------------------------------------------------------------
// HID keyboard report builder: report engine
// Applies one command to the report state, then streams the report bytes.
// ----------------------------------------------------------------------------
`include "hid_keyboard_report_builder_unit_defines.svh"

module hkrb_back import hkrb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata,
  input  q_status_t q_status,
  input  cmd_t      head_cmd,
  output logic      q_pop,
  output logic      out_valid,
  output out_item_t out_item
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       report_id_r;
  logic [7:0]       mod_r, mod_nxt;
  logic [7:0]       slots_r   [KEY_SLOT_COUNT];
  logic [7:0]       slots_nxt [KEY_SLOT_COUNT];
  logic             out_valid_r;
  out_item_t        out_item_r, out_item_nxt;

  logic [KEY_SLOT_COUNT-1:0] hit_empty, hit_match;
  logic                      found_empty, found_match;
  logic                      last_byte;
  logic [SLOT_W-1:0]         slot_sel;

  assign last_byte = (cnt_r == CNT_W'(REPORT_LEN - 1));
  assign slot_sel  = SLOT_W'(cnt_r - CNT_W'(HEADER_LEN));

  // lowest empty slot and lowest slot holding the code
  always_comb begin
    hit_empty   = '0;
    hit_match   = '0;
    found_empty = 1'b0;
    found_match = 1'b0;
    for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
      if (!found_empty && slots_r[i] == 8'h00) begin
        hit_empty[i] = 1'b1;
        found_empty  = 1'b1;
      end
      if (!found_match && slots_r[i] == head_cmd.code) begin
        hit_match[i] = 1'b1;
        found_match  = 1'b1;
      end
    end
  end

  always_comb begin
    mod_nxt = mod_r;
    for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
      slots_nxt[i] = slots_r[i];
    end
    unique case (head_cmd.kind)
      CMD_MOD_SET: mod_nxt = mod_r | head_cmd.code;
      CMD_MOD_CLR: mod_nxt = mod_r & ~head_cmd.code;
      CMD_KEY_PRESS: begin
        for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
          if (hit_empty[i]) begin
            slots_nxt[i] = head_cmd.code;
          end
        end
      end
      CMD_KEY_REL: begin
        for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
          if (hit_match[i]) begin
            slots_nxt[i] = 8'h00;
          end
        end
      end
      CMD_CLR_ALL: begin
        mod_nxt = 8'h00;
        for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
          slots_nxt[i] = 8'h00;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          q_pop     = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (last_byte) begin
          cnt_nxt = '0;
          if (!q_status.empty) begin
            q_pop = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_item_nxt.byte_index = IDX_W'(cnt_r);
    out_item_nxt.last       = last_byte;
    case (cnt_r)
      CNT_W'(0): out_item_nxt.report_byte = report_id_r;
      CNT_W'(1): out_item_nxt.report_byte = mod_r;
      CNT_W'(2): out_item_nxt.report_byte = 8'h00;
      default:   out_item_nxt.report_byte = slots_r[slot_sel];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      report_id_r <= REPORT_ID_RST;
      mod_r       <= 8'h00;
      out_valid_r <= 1'b0;
      for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
        slots_r[i] <= 8'h00;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= (state_r == ST_EMIT);
      if (cfg_we) begin
        report_id_r <= cfg_wdata;
      end
      if (q_pop) begin
        mod_r <= mod_nxt;
        for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
          slots_r[i] <= slots_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `HKRB_ASSERT(a_last_pos, out_valid_r && out_item_r.last |-> out_item_r.byte_index == IDX_W'(REPORT_LEN - 1), "last flag off the final byte")
  `HKRB_ASSERT(a_emit_strobe, state_r == ST_EMIT |=> out_valid_r, "emit cycle without strobe")
  `HKRB_NEVER(a_pop_mid_report, q_pop && state_r == ST_EMIT && !last_byte, "update during report")

endmodule

@@ hw/rtl/hid_keyboard_report_builder_unit.sv @@
// ----------------------------------------------------------------------------
// HID keyboard report builder (boot keyboard, six-key rollover)
// Keeps the modifier byte and key slots and emits a nine-byte report per event.
// ----------------------------------------------------------------------------
// Each accepted event produces nine report bytes (report id, modifiers, zero,
// six key slots) on out_valid back to back, byte 0 first. The byte serializer
// limits the sustained event rate; the state update of the next event overlaps
// the last byte of the current one. A two-entry command queue takes events
// while a report streams; busy is high only while it is full. Results cannot
// be stalled. Write cfg_wdata only while idle.
// ----------------------------------------------------------------------------
module hid_keyboard_report_builder_unit import hkrb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output logic       out_valid,
  output out_item_t  out_item
);

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  cmd_t      push_cmd;
  cmd_t      head_cmd;

  hkrb_front u_front (
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .q_status (q_status),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  hkrb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  hkrb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_status  (q_status),
    .head_cmd  (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
